>>> rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top file
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is held
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/hcv_pkg.sv
// types, constants and the pixel classifier for the hsv colour vote block
// no dependencies
package hcv_pkg;

  // confidence format, unsigned q0.16
  localparam int CONF_W    = 16;
  localparam int DIV_CNT_W = $clog2(CONF_W);

  // pixel thresholds
  localparam logic [7:0] RED_HUE_MAX  = 8'd26;
  localparam logic [7:0] RED_SAT_MIN  = 8'd200;
  localparam logic [7:0] RED_VAL_MIN  = 8'd240;
  localparam logic [7:0] YEL_HUE_MAX  = 8'd42;
  localparam logic [7:0] YEL_SAT_MIN  = 8'd50;
  localparam logic [7:0] YEL_VAL_MIN  = 8'd240;
  localparam logic [7:0] GRN_HUE_LOW  = 8'd80;
  localparam logic [7:0] GRN_HUE_HIGH = 8'd105;
  localparam logic [7:0] GRN_SAT_MIN  = 8'd50;
  localparam logic [7:0] GRN_VAL_MIN  = 8'd190;

  typedef enum logic [1:0] {
    COLOR_RED    = 2'd0,
    COLOR_YELLOW = 2'd1,
    COLOR_GREEN  = 2'd2
  } color_e;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_RED,
    CLS_YELLOW,
    CLS_GREEN
  } pix_class_e;

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_DIVIDE,
    ST_HOLD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;    // pixel request taken this cycle
    logic step_div;  // one quotient bit
    logic load_out;  // move the quotient into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;  // current step is the final quotient bit
    logic out_free;  // output register can take a new result
  } status_t;

  // class of one pixel, tests in priority order red, yellow, green
  function automatic pix_class_e hcv_classify(logic [7:0] h, logic [7:0] s, logic [7:0] v);
    pix_class_e cls;
    cls = CLS_NONE;
    if (h < RED_HUE_MAX && s > RED_SAT_MIN && v > RED_VAL_MIN) begin
      cls = CLS_RED;
    end else if (h < YEL_HUE_MAX && s > YEL_SAT_MIN && v > YEL_VAL_MIN) begin
      cls = CLS_YELLOW;
    end else if (h > GRN_HUE_LOW && h < GRN_HUE_HIGH && s > GRN_SAT_MIN
                 && v > GRN_VAL_MIN) begin
      cls = CLS_GREEN;
    end
    return cls;
  endfunction

endpackage

>>> rtl/hcv_ctrl.sv
// controller state machine: pixel counting, serial divide, result hand-off
// depends on hcv_pkg
module hcv_ctrl import hcv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    last_pixel_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o,
  output state_e  state_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COUNT: begin
        if (in_valid_i && last_pixel_i) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          state_d = ST_COUNT;
        end
      end
      default: state_d = ST_COUNT;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_COUNT: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DIVIDE: begin
        cmd_o.step_div = 1'b1;
      end
      ST_HOLD: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

>>> rtl/hcv_datapath.sv
// datapath: vote counters, winner pick, restoring divider, output register
// depends on hcv_pkg
module hcv_datapath import hcv_pkg::*; #(
  parameter int MAX_REGION_PIXELS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [7:0]        hue_i,
  input  logic [7:0]        saturation_i,
  input  logic [7:0]        brightness_i,
  input  logic              last_pixel_i,
  input  logic              out_ready_i,
  output status_t           status_o,
  output logic              out_valid_o,
  output logic [1:0]        light_color_o,
  output logic [CONF_W-1:0] confidence_o
);

  localparam int CntW = $clog2(MAX_REGION_PIXELS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_REGION_PIXELS);

  logic [CntW-1:0] red_q, yel_q, grn_q, total_q;
  logic [CntW-1:0] red_nx, yel_nx, grn_nx, total_nx;
  logic [CntW-1:0] yel_half, win;
  color_e          color;
  pix_class_e      cls;

  logic [CntW:0]          rem_q, shifted;
  logic [CntW-1:0]        den_q;
  logic [CONF_W-1:0]      quo_q, conf_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   sat_q, out_valid_q;
  color_e                 color_q, out_color_q;

  // counters after the current pixel, ignoring pixels once the region is full
  always_comb begin
    cls      = hcv_classify(hue_i, saturation_i, brightness_i);
    red_nx   = red_q;
    yel_nx   = yel_q;
    grn_nx   = grn_q;
    total_nx = total_q;
    if (total_q != MaxCnt) begin
      total_nx = total_q + CntW'(1);
      case (cls)
        CLS_RED:    red_nx = red_q + CntW'(1);
        CLS_YELLOW: yel_nx = yel_q + CntW'(1);
        CLS_GREEN:  grn_nx = grn_q + CntW'(1);
        default:    red_nx = red_q;
      endcase
    end
  end

  // winner pick with the halved yellow count, ties go to yellow
  always_comb begin
    yel_half = yel_nx >> 1;
    if (red_nx > grn_nx && red_nx > yel_half) begin
      color = COLOR_RED;
      win   = red_nx;
    end else if (grn_nx > red_nx && grn_nx > yel_half) begin
      color = COLOR_GREEN;
      win   = grn_nx;
    end else begin
      color = COLOR_YELLOW;
      win   = yel_half;
    end
  end

  // vote counters, cleared after the last pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= '0;
      yel_q   <= '0;
      grn_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.accept) begin
      if (last_pixel_i) begin
        red_q   <= '0;
        yel_q   <= '0;
        grn_q   <= '0;
        total_q <= '0;
      end else begin
        red_q   <= red_nx;
        yel_q   <= yel_nx;
        grn_q   <= grn_nx;
        total_q <= total_nx;
      end
    end
  end

  // restoring divide of win * 2^16 by total, remainder stays below divisor
  assign shifted = {rem_q[CntW-1:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.accept && last_pixel_i) begin
      cnt_q <= DIV_CNT_W'(CONF_W - 1);
    end else if (cmd_i.step_div && cnt_q != '0) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && last_pixel_i) begin
      rem_q   <= {1'b0, win};
      den_q   <= total_nx;
      sat_q   <= (win >= total_nx);
      quo_q   <= '0;
      color_q <= color;
    end else if (cmd_i.step_div) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_q <= shifted - {1'b0, den_q};
        quo_q <= {quo_q[CONF_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[CONF_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      conf_q      <= sat_q ? '1 : quo_q;
      out_color_q <= color_q;
    end
  end

  assign status_o.div_done = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign light_color_o     = out_color_q;
  assign confidence_o      = conf_q;

endmodule

>>> rtl/hsv_color_vote_classifier_top.sv
// channel  dir  handshake              payload
// in       in   in_valid_i/in_ready_o  hue_i, saturation_i, brightness_i, last_pixel_i
// out      out  out_valid_o/out_ready_i light_color_o, confidence_o
//
// one pixel request a cycle while counting; after the last pixel of a region
// the serial divider works out the quotient bit by bit, the result is loaded once the
// output register is free, and only then is the next region's first pixel taken.
// reset clears the vote counters, state machine and output valid.
// a stalled result holds in the output register while counting goes on.
`include "assert_macros.svh"

module hsv_color_vote_classifier_top import hcv_pkg::*; #(
  parameter int MAX_REGION_PIXELS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        hue_i,
  input  logic [7:0]        saturation_i,
  input  logic [7:0]        brightness_i,
  input  logic              last_pixel_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        light_color_o,
  output logic [CONF_W-1:0] confidence_o
);

  cmd_t    cmd;
  status_t status;
  state_e  state;
  logic    last_taken;

  // controller
  hcv_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_pixel_i (last_pixel_i),
    .status_i     (status),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd),
    .state_o      (state)
  );

  // datapath
  hcv_datapath #(
    .MAX_REGION_PIXELS (MAX_REGION_PIXELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .brightness_i  (brightness_i),
    .last_pixel_i  (last_pixel_i),
    .out_ready_i   (out_ready_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .light_color_o (light_color_o),
    .confidence_o  (confidence_o)
  );

  // last pixel of a region taken this cycle
  assign last_taken = in_valid_i && in_ready_o && last_pixel_i;

  // checks
  `ASSERT_RST(a_no_pixel_during_divide, last_taken |-> ##17 !in_ready_o, "pixel taken too early")
  `ASSERT_RST(a_load_from_hold, $rose(out_valid_o) |-> $past(state == ST_HOLD), "load outside hold")
  `ASSERT_RST(a_color_code, out_valid_o |-> light_color_o <= COLOR_GREEN, "invalid colour code")

endmodule
